@@ rtl/flux_stream_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Flux stream decoder assertion macros
// Concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef FLUX_STREAM_DECODER_ASSERT_SVH
`define FLUX_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on each rising edge outside reset
`define FSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("flux stream decoder assertion failed");
// Check that a condition never holds outside reset
`define FSD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("flux stream decoder forbidden condition seen");
`else
`define FSD_ASSERT(lbl, clk, rst_n, prop)
`define FSD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ rtl/fsd_pkg.sv @@
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types and constants of the flux stream decoder.
// ----------------------------------------------------------------------------
package fsd_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_FLUX  = 2'd0,
        KIND_INDEX = 2'd1,
        KIND_INFO  = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    // One accepted input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_beat;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [31:0] flux_time;
        logic [31:0] flux_number;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic        code_present;
    } t_result;

    // Opcode map
    localparam logic [7:0] OP_FLUX2_MAX = 8'h07;
    localparam logic [7:0] OP_NOP1      = 8'h08;
    localparam logic [7:0] OP_NOP3      = 8'h0A;
    localparam logic [7:0] OP_OVERFLOW  = 8'h0B;
    localparam logic [7:0] OP_FLUX3     = 8'h0C;
    localparam logic [7:0] OP_OOB       = 8'h0D;

    // Out-of-band block types
    localparam logic [7:0] BLK_FLUX2    = 8'h00;
    localparam logic [7:0] BLK_INFO     = 8'h01;
    localparam logic [7:0] BLK_INDEX    = 8'h02;
    localparam logic [7:0] BLK_END      = 8'h03;
    localparam logic [7:0] BLK_EOF      = 8'h0D;

    // Block length thresholds and payload storage span
    localparam logic [15:0] INFO_MIN_LEN  = 16'd8;
    localparam logic [15:0] INDEX_MIN_LEN = 16'd12;
    localparam logic [15:0] END_CODE_LEN  = 16'd8;
    localparam logic [15:0] STORE_BYTES   = 16'd12;
    localparam int          PAYLOAD_WORDS = 3;

    localparam logic [31:0] OVERFLOW_STEP = 32'h0001_0000;

    // Configuration port
    localparam int          CFG_ADDR_W        = 3;
    localparam logic        REG_INDEX_LIMIT   = 1'b0;
    localparam logic [7:0]  INDEX_LIMIT_RESET = 8'd20;

    localparam int OUT_TDATA_W = 168;

endpackage

@@ rtl/flux_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// flux_stream_decoder
// Floppy flux stream decoder with out-of-band block records.
// ----------------------------------------------------------------------------
// Takes one stream byte per beat and returns at most one result per byte:
// a flux time with its running number, or a stream info, index or stream end
// record when an out-of-band block closes. A byte is taken every cycle while
// the result side keeps up; a result passes from the input register through
// the parser into the result register before it is presented, and a full
// result register can hold it back. The parser state update sets this rate.
// Write the index limit only while the stream is idle. tlast on the last byte
// clears stream state.
// ----------------------------------------------------------------------------
module flux_stream_decoder
    import fsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // stream in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,   // end_of_buffer
    // stream out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] flux_time, [63:32] flux_number, [95:64] word_a, [127:96] word_b,
    // [159:128] word_c, [160] code_present, [167:161] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]             m_axis_tuser,   // [1:0] kind
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic       [7:0] index_limit;
    t_in_beat         s_beat;
    t_in_beat         in_beat;
    logic             in_valid;
    logic             slot_free;
    logic             adv;
    logic             emit;
    t_result          result;
    t_result          out_result;

    fsd_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_index_limit (index_limit)
    );

    assign s_beat.data_byte     = s_axis_tdata;
    assign s_beat.end_of_buffer = s_axis_tlast;

    fsd_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .i_beat   (s_beat),
        .o_tready (s_axis_tready),
        .i_adv    (adv),
        .o_valid  (in_valid),
        .o_beat   (in_beat)
    );

    // Advance the held byte when the result slot can take its outcome
    assign adv = in_valid && slot_free;

    fsd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_beat        (in_beat),
        .i_index_limit (index_limit),
        .o_emit        (emit),
        .o_result      (result)
    );

    fsd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_emit      (emit),
        .i_result    (result),
        .i_tready    (m_axis_tready),
        .o_slot_free (slot_free),
        .o_tvalid    (m_axis_tvalid),
        .o_result    (out_result)
    );

    // Pack the result beat
    assign m_axis_tdata = {7'd0,
                           out_result.code_present,
                           out_result.word_c,
                           out_result.word_b,
                           out_result.word_a,
                           out_result.flux_number,
                           out_result.flux_time};
    assign m_axis_tuser = out_result.kind;

endmodule

@@ rtl/fsd_apb_regs.sv @@
// ----------------------------------------------------------------------------
// fsd_apb_regs
// APB register file holding the index record limit.
// ----------------------------------------------------------------------------
module fsd_apb_regs
    import fsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [7:0]            o_index_limit
);

    logic [7:0] r_index_limit;
    logic       wr_en;

    // Decode a completed write to the limit register
    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_INDEX_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_limit <= INDEX_LIMIT_RESET;
        end else if (wr_en) begin
            r_index_limit <= pwdata[7:0];
        end
    end

    // Read back, zero beyond the register list
    assign prdata        = (paddr[2] == REG_INDEX_LIMIT) ? {24'd0, r_index_limit} : 32'd0;
    assign pready        = 1'b1;
    assign o_index_limit = r_index_limit;

endmodule

@@ rtl/fsd_in_stage.sv @@
// ----------------------------------------------------------------------------
// fsd_in_stage
// Input register that captures one stream beat for the parser.
// ----------------------------------------------------------------------------
module fsd_in_stage
    import fsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_tvalid,
    input  t_in_beat i_beat,
    output logic     o_tready,
    input  logic     i_adv,
    output logic     o_valid,
    output t_in_beat o_beat
);

    logic     r_valid;
    t_in_beat r_beat;

    // Take a new beat when empty or when the held beat moves on
    assign o_tready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

@@ rtl/fsd_parser.sv @@
// ----------------------------------------------------------------------------
// fsd_parser
// Opcode and out-of-band block parser; one byte per advance.
// ----------------------------------------------------------------------------
`include "flux_stream_decoder_assert.svh"

module fsd_parser
    import fsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_in_beat   i_beat,
    input  logic [7:0] i_index_limit,
    output logic       o_emit,
    output t_result    o_result
);

    typedef enum logic [3:0] {
        PH_OPCODE  = 4'd0,
        PH_FLUX2   = 4'd1,
        PH_FLUX3A  = 4'd2,
        PH_FLUX3B  = 4'd3,
        PH_SKIP    = 4'd4,
        PH_OOBTYPE = 4'd5,
        PH_LENLO   = 4'd6,
        PH_LENHI   = 4'd7,
        PH_PAYLOAD = 4'd8
    } t_phase;

    t_phase      r_phase,       n_phase;
    logic [7:0]  r_partial,     n_partial;
    logic [7:0]  r_block_type,  n_block_type;
    logic [15:0] r_block_len,   n_block_len;
    logic [15:0] r_bytes_left,  n_bytes_left;
    logic [31:0] r_words [PAYLOAD_WORDS];
    logic [31:0] n_words [PAYLOAD_WORDS];
    logic [31:0] r_overflow,    n_overflow;
    logic [31:0] r_flux_total,  n_flux_total;
    logic [7:0]  r_index_total, n_index_total;
    logic        r_eof,         n_eof;

    logic [7:0]  b;
    logic        do_flux;
    logic        do_finish;
    logic [31:0] flux_val;
    logic [15:0] fin_len;
    logic [15:0] len_full;
    logic [15:0] offset;
    logic        emit;
    t_result     res;

    assign b = i_beat.data_byte;

    // Decode the current byte and work out the next state
    always_comb begin
        n_phase       = r_phase;
        n_partial     = r_partial;
        n_block_type  = r_block_type;
        n_block_len   = r_block_len;
        n_bytes_left  = r_bytes_left;
        n_overflow    = r_overflow;
        n_flux_total  = r_flux_total;
        n_index_total = r_index_total;
        n_eof         = r_eof;
        for (int w = 0; w < PAYLOAD_WORDS; w++) begin
            n_words[w] = r_words[w];
        end
        do_flux   = 1'b0;
        do_finish = 1'b0;
        flux_val  = 32'd0;
        fin_len   = r_block_len;
        len_full  = {b, r_block_len[7:0]};
        offset    = r_block_len - r_bytes_left;
        emit      = 1'b0;
        res       = '0;

        if (i_adv && !r_eof) begin
            case (r_phase)
                PH_FLUX2, PH_FLUX3B: begin
                    n_phase  = PH_OPCODE;
                    do_flux  = 1'b1;
                    flux_val = {16'd0, r_partial, b};
                end
                PH_FLUX3A: begin
                    n_partial = b;
                    n_phase   = PH_FLUX3B;
                end
                PH_SKIP: begin
                    if (r_bytes_left != 16'd0) begin
                        n_bytes_left = r_bytes_left - 16'd1;
                    end
                    if (r_bytes_left <= 16'd1) begin
                        n_phase = PH_OPCODE;
                    end
                end
                PH_OOBTYPE: begin
                    if (b == BLK_FLUX2) begin
                        // escape followed by zero type starts a two-byte flux
                        n_partial = 8'd0;
                        n_phase   = PH_FLUX2;
                    end else begin
                        n_block_type = b;
                        if (b == BLK_EOF) begin
                            n_eof   = 1'b1;
                            n_phase = PH_OPCODE;
                        end else begin
                            n_phase = PH_LENLO;
                        end
                    end
                end
                PH_LENLO: begin
                    n_block_len = {8'd0, b};
                    n_phase     = PH_LENHI;
                end
                PH_LENHI: begin
                    n_block_len  = len_full;
                    n_bytes_left = len_full;
                    fin_len      = len_full;
                    if (len_full == 16'd0) begin
                        do_finish = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    // store the first payload bytes little-endian
                    if (offset < STORE_BYTES) begin
                        for (int w = 0; w < PAYLOAD_WORDS; w++) begin
                            for (int k = 0; k < 4; k++) begin
                                if ((offset[3:2] == 2'(w)) && (offset[1:0] == 2'(k))) begin
                                    n_words[w][8*k +: 8] = b;
                                end
                            end
                        end
                    end
                    n_bytes_left = r_bytes_left - 16'd1;
                    if (r_bytes_left == 16'd1) begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_OPCODE;
                    if (b <= OP_FLUX2_MAX) begin
                        n_partial = b;
                        n_phase   = PH_FLUX2;
                    end else if (b == OP_NOP1) begin
                        n_phase = PH_OPCODE;
                    end else if (b <= OP_NOP3) begin
                        n_bytes_left = {8'd0, b} - {8'd0, OP_NOP1};
                        n_phase      = PH_SKIP;
                    end else if (b == OP_OVERFLOW) begin
                        n_overflow = r_overflow + OVERFLOW_STEP;
                    end else if (b == OP_FLUX3) begin
                        n_phase = PH_FLUX3A;
                    end else if (b == OP_OOB) begin
                        n_phase = PH_OOBTYPE;
                    end else begin
                        do_flux  = 1'b1;
                        flux_val = {24'd0, b};
                    end
                end
            endcase
        end

        // Emit a flux time with any pending overflow
        if (do_flux) begin
            emit            = 1'b1;
            res.kind        = KIND_FLUX;
            res.flux_time   = flux_val + r_overflow;
            res.flux_number = r_flux_total;
            n_overflow      = 32'd0;
            n_flux_total    = r_flux_total + 32'd1;
        end

        // Close an out-of-band block and report its record
        if (do_finish) begin
            n_phase         = PH_OPCODE;
            res.flux_number = r_flux_total;
            case (r_block_type)
                BLK_INFO: begin
                    if (fin_len >= INFO_MIN_LEN) begin
                        emit       = 1'b1;
                        res.kind   = KIND_INFO;
                        res.word_a = n_words[0];
                        res.word_b = n_words[1];
                    end
                end
                BLK_INDEX: begin
                    if ((fin_len >= INDEX_MIN_LEN) && (r_index_total < i_index_limit)) begin
                        emit          = 1'b1;
                        res.kind      = KIND_INDEX;
                        res.word_a    = n_words[0];
                        res.word_b    = n_words[1];
                        res.word_c    = n_words[2];
                        n_index_total = r_index_total + 8'd1;
                    end
                end
                BLK_END: begin
                    emit     = 1'b1;
                    res.kind = KIND_END;
                    if (fin_len >= END_CODE_LEN) begin
                        res.word_b       = n_words[1];
                        res.code_present = 1'b1;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end

        // Drop all stream state after the last byte of a buffer
        if (i_adv && i_beat.end_of_buffer) begin
            n_phase       = PH_OPCODE;
            n_partial     = 8'd0;
            n_block_type  = 8'd0;
            n_block_len   = 16'd0;
            n_bytes_left  = 16'd0;
            n_overflow    = 32'd0;
            n_flux_total  = 32'd0;
            n_index_total = 8'd0;
            n_eof         = 1'b0;
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_OPCODE;
            r_partial     <= 8'd0;
            r_block_type  <= 8'd0;
            r_block_len   <= 16'd0;
            r_bytes_left  <= 16'd0;
            r_overflow    <= 32'd0;
            r_flux_total  <= 32'd0;
            r_index_total <= 8'd0;
            r_eof         <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_partial     <= n_partial;
            r_block_type  <= n_block_type;
            r_block_len   <= n_block_len;
            r_bytes_left  <= n_bytes_left;
            r_overflow    <= n_overflow;
            r_flux_total  <= n_flux_total;
            r_index_total <= n_index_total;
            r_eof         <= n_eof;
        end
    end

    // Payload words carry no reset; every field read was written first
    always_ff @(posedge i_clk) begin
        for (int w = 0; w < PAYLOAD_WORDS; w++) begin
            r_words[w] <= n_words[w];
        end
    end

    assign o_emit   = emit;
    assign o_result = res;

    `FSD_ASSERT(a_clear_after_last, i_clk, i_rst_n,
        (i_adv && i_beat.end_of_buffer)
            |=> ((r_phase == PH_OPCODE) && (r_flux_total == 32'd0) && !r_eof))
    `FSD_ASSERT_NEVER(a_no_emit_after_eof, i_clk, i_rst_n, r_eof && emit)
    `FSD_ASSERT_NEVER(a_skip_has_count, i_clk, i_rst_n,
        (r_phase == PH_SKIP) && (r_bytes_left == 16'd0))

endmodule

@@ rtl/fsd_out_stage.sv @@
// ----------------------------------------------------------------------------
// fsd_out_stage
// Result register that holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module fsd_out_stage
    import fsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  logic    i_emit,
    input  t_result i_result,
    input  logic    i_tready,
    output logic    o_slot_free,
    output logic    o_tvalid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Slot frees when empty or when the held beat is taken this cycle
    assign o_slot_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_emit;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_result = r_result;

endmodule

@@ test/flux_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flux_scoreboard_pkg
// Expected-record tracking for the flux stream decoder testbench. The class
// keeps its own copy of the parser state, works out the records that each
// accepted stream byte produces and compares arriving records against them.
// ----------------------------------------------------------------------------
package flux_scoreboard_pkg;
    import fsd_pkg::*;

    // Parser position within the current stream item
    typedef enum logic [3:0] {
        ST_OPCODE,
        ST_FLUX2,
        ST_FLUX3_HI,
        ST_FLUX3_LO,
        ST_SKIP,
        ST_OOB_TYPE,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_PAYLOAD
    } t_parse_state;

    localparam int REPORT_LIMIT = 10;

    class flux_scoreboard;
        t_result      expected_records[$];
        int           mismatches;
        logic [7:0]   index_limit;
        t_parse_state state;
        logic [7:0]   partial;
        logic [7:0]   block_kind;
        logic [15:0]  block_len;
        logic [15:0]  bytes_left;
        logic [31:0]  payload[PAYLOAD_WORDS];
        logic [31:0]  overflow_sum;
        logic [31:0]  flux_tally;
        logic [7:0]   index_tally;
        bit           after_eof;

        function new();
            mismatches  = 0;
            index_limit = INDEX_LIMIT_RESET;
            clear_stream();
        endfunction

        function void set_index_limit(logic [7:0] value);
            index_limit = value;
        endfunction

        // Return to the start-of-stream state
        function void clear_stream();
            state        = ST_OPCODE;
            partial      = '0;
            block_kind   = '0;
            block_len    = '0;
            bytes_left   = '0;
            foreach (payload[i]) payload[i] = '0;
            overflow_sum = '0;
            flux_tally   = '0;
            index_tally  = '0;
            after_eof    = 1'b0;
        endfunction

        // Queue one flux time with the pending overflow folded in
        function void emit_flux_time(logic [31:0] value);
            t_result r;
            r             = '0;
            r.kind        = KIND_FLUX;
            r.flux_time   = value + overflow_sum;
            r.flux_number = flux_tally;
            expected_records.push_back(r);
            overflow_sum  = '0;
            flux_tally    = flux_tally + 32'd1;
        endfunction

        // Queue the record of a finished out-of-band block, if it makes one
        function void close_block();
            t_result r;
            r             = '0;
            r.flux_number = flux_tally;
            state         = ST_OPCODE;
            case (block_kind)
                BLK_INFO: begin
                    if (block_len >= INFO_MIN_LEN) begin
                        r.kind   = KIND_INFO;
                        r.word_a = payload[0];
                        r.word_b = payload[1];
                        expected_records.push_back(r);
                    end
                end
                BLK_INDEX: begin
                    if (block_len >= INDEX_MIN_LEN && index_tally < index_limit) begin
                        r.kind      = KIND_INDEX;
                        r.word_a    = payload[0];
                        r.word_b    = payload[1];
                        r.word_c    = payload[2];
                        expected_records.push_back(r);
                        index_tally = index_tally + 8'd1;
                    end
                end
                BLK_END: begin
                    r.kind = KIND_END;
                    if (block_len >= END_CODE_LEN) begin
                        r.word_b       = payload[1];
                        r.code_present = 1'b1;
                    end
                    expected_records.push_back(r);
                end
                default: begin
                    // unknown block types are consumed silently
                end
            endcase
        endfunction

        // Advance the parser by one accepted stream beat
        function void note_byte(logic [7:0] value, logic last);
            logic [15:0] offset;
            if (!after_eof) begin
                case (state)
                    ST_FLUX2, ST_FLUX3_LO: begin
                        state = ST_OPCODE;
                        emit_flux_time({16'd0, partial, value});
                    end
                    ST_FLUX3_HI: begin
                        partial = value;
                        state   = ST_FLUX3_LO;
                    end
                    ST_SKIP: begin
                        if (bytes_left != 0) bytes_left = bytes_left - 16'd1;
                        if (bytes_left == 0) state = ST_OPCODE;
                    end
                    ST_OOB_TYPE: begin
                        if (value == BLK_FLUX2) begin
                            // escape followed by a two-byte flux
                            partial = '0;
                            state   = ST_FLUX2;
                        end else begin
                            block_kind = value;
                            if (value == BLK_EOF) begin
                                after_eof = 1'b1;
                                state     = ST_OPCODE;
                            end else begin
                                state = ST_LEN_LO;
                            end
                        end
                    end
                    ST_LEN_LO: begin
                        block_len = {8'd0, value};
                        state     = ST_LEN_HI;
                    end
                    ST_LEN_HI: begin
                        block_len[15:8] = value;
                        bytes_left      = block_len;
                        foreach (payload[i]) payload[i] = '0;
                        if (bytes_left == 0) close_block();
                        else state = ST_PAYLOAD;
                    end
                    ST_PAYLOAD: begin
                        // keep only the first three payload words
                        offset = block_len - bytes_left;
                        if (offset < STORE_BYTES)
                            payload[offset[3:2]] = payload[offset[3:2]]
                                | ({24'd0, value} << (8 * offset[1:0]));
                        bytes_left = bytes_left - 16'd1;
                        if (bytes_left == 0) close_block();
                    end
                    default: begin
                        // opcode byte
                        state = ST_OPCODE;
                        if (value <= OP_FLUX2_MAX) begin
                            partial = value;
                            state   = ST_FLUX2;
                        end else if (value == OP_NOP1) begin
                            // single-byte no-op: nothing to do
                        end else if (value <= OP_NOP3) begin
                            bytes_left = 16'(value - OP_NOP1);
                            state      = ST_SKIP;
                        end else if (value == OP_OVERFLOW) begin
                            overflow_sum = overflow_sum + OVERFLOW_STEP;
                        end else if (value == OP_FLUX3) begin
                            state = ST_FLUX3_HI;
                        end else if (value == OP_OOB) begin
                            state = ST_OOB_TYPE;
                        end else begin
                            emit_flux_time({24'd0, value});
                        end
                    end
                endcase
            end
            if (last) clear_stream();
        endfunction

        function string describe(t_result r);
            return $sformatf("kind %0d time %h num %h a %h b %h c %h code %b",
                             r.kind, r.flux_time, r.flux_number, r.word_a, r.word_b,
                             r.word_c, r.code_present);
        endfunction

        // Compare an arriving record with the oldest one expected
        function void check_result(t_result got);
            t_result want;
            bit      same;
            if (expected_records.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected record: %s", $time, describe(got));
                return;
            end
            want = expected_records.pop_front();
            same = (got.kind === want.kind) && (got.flux_time === want.flux_time)
                && (got.flux_number === want.flux_number) && (got.word_a === want.word_a)
                && (got.word_b === want.word_b) && (got.word_c === want.word_c)
                && (got.code_present === want.code_present);
            if (!same) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("[%0t] record mismatch", $time);
                    $display("    expected %s", describe(want));
                    $display("    actual   %s", describe(got));
                end
            end
        endfunction
    endclass

endpackage

@@ test/tb_flux_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flux_stream_decoder
// Drives flux stream bytes into the decoder under random backpressure on both
// sides, steps the index limit through several values between phases, and
// checks every output record against a behavioral copy of the parser.
// ----------------------------------------------------------------------------
module tb_flux_stream_decoder;
    import fsd_pkg::*;
    import flux_scoreboard_pkg::*;

    localparam int         QUIET_LIMIT  = 1000;
    localparam int         HOLD_CYCLES  = 64;
    localparam int         PHASE_BEATS  = 185;
    localparam int         NUM_PHASES   = 5;
    localparam logic [7:0] FLUX1_MIN    = OP_OOB + 8'd1;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;   // [7:0] data_byte
    logic                   s_axis_tlast  = 1'b0; // end_of_buffer
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] flux_time, [63:32] flux_number, [95:64] word_a, [127:96] word_b,
    // [159:128] word_c, [160] code_present
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;         // [1:0] kind
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr         = '0;
    logic [31:0]            pwdata        = '0;
    logic [31:0]            prdata;
    logic                   pready;

    flux_scoreboard flux_check;
    bit             tx_gaps      = 1'b1;
    bit             rx_gaps      = 1'b1;
    bit             rx_hold_req  = 1'b0;
    int             stream_left;
    int             beats_sent   = 0;
    int             quiet_cycles = 0;

    flux_stream_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Note input beats and check output beats on each edge
    always @(posedge i_clk) begin : beat_monitor
        t_result got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                flux_check.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind         = t_kind'(m_axis_tuser);
                got.flux_time    = m_axis_tdata[31:0];
                got.flux_number  = m_axis_tdata[63:32];
                got.word_a       = m_axis_tdata[95:64];
                got.word_b       = m_axis_tdata[127:96];
                got.word_c       = m_axis_tdata[159:128];
                got.code_present = m_axis_tdata[160];
                flux_check.check_result(got);
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Offer one beat, with an optional idle burst ahead of it
    task automatic send_beat(input logic [7:0] value, input logic last);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    // Send a byte of the running stream; close the stream when its length runs out
    task automatic put_byte(input logic [7:0] value);
        stream_left--;
        send_beat(value, stream_left == 0);
        if (stream_left == 0) stream_left = $urandom_range(8, 160);
    endtask

    task automatic send_stream(input logic [7:0] bytes[$]);
        foreach (bytes[i]) send_beat(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic put_block(input logic [7:0] btype, input int len);
        put_byte(OP_OOB);
        put_byte(btype);
        put_byte(8'(len));
        put_byte(8'(len >> 8));
        repeat (len) put_byte(8'($urandom));
    endtask

    // One stream item with random content; mostly well formed, some noise
    task automatic put_item(input int index_bias);
        int         pick;
        int         nop;
        logic [7:0] btype;
        pick = $urandom_range(0, 99);
        if (pick < index_bias) begin
            put_block(BLK_INDEX, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20)
                                                              : int'(INDEX_MIN_LEN));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                put_byte(8'($urandom_range(FLUX1_MIN, 255)));
            end else if (pick < 40) begin
                put_byte(8'($urandom_range(0, OP_FLUX2_MAX)));
                put_byte(8'($urandom));
            end else if (pick < 46) begin
                put_byte(OP_FLUX3);
                put_byte(8'($urandom));
                put_byte(8'($urandom));
            end else if (pick < 52) begin
                nop = $urandom_range(OP_NOP1, OP_NOP3);
                put_byte(8'(nop));
                repeat (nop - OP_NOP1) put_byte(8'($urandom));
            end else if (pick < 58) begin
                repeat ($urandom_range(1, 3)) put_byte(OP_OVERFLOW);
            end else if (pick < 62) begin
                put_byte(OP_OOB);
                put_byte(BLK_FLUX2);
                put_byte(8'($urandom));
            end else if (pick < 70) begin
                put_block(BLK_INFO, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16)
                                                                 : int'(INFO_MIN_LEN));
            end else if (pick < 76) begin
                put_block(BLK_END, $urandom_range(0, 10));
            end else if (pick < 80) begin
                btype = 8'($urandom_range(BLK_END + 1, 255));
                if (btype == BLK_EOF) btype = BLK_END + 8'd1;
                put_block(btype, $urandom_range(0, 6));
            end else if (pick == 80 && $urandom_range(0, 3) == 0) begin
                put_byte(OP_OOB);
                put_byte(BLK_EOF);
            end else begin
                put_byte(8'($urandom));
            end
        end
    endtask

    // Wait until every expected record is out and the parser has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (flux_check.expected_records.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_index_limit(input logic [7:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CFG_ADDR_W'(4 * int'(REG_INDEX_LIMIT));
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        flux_check.set_index_limit(value);
    endtask

    initial begin
        logic [7:0] limit_steps[NUM_PHASES] = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd0};
        int         index_bias[NUM_PHASES]  = '{25, 10, 25, 25, 10};
        int         phase_start;
        logic [7:0] limit;

        flux_check  = new();
        stream_left = $urandom_range(8, 160);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every opcode, escape to flux, empty end block,
        // partial item with pending overflow dropped at end of buffer
        send_stream('{FLUX1_MIN, 8'hFF, 8'h00, 8'h00, OP_FLUX2_MAX, 8'hFF, OP_NOP1,
                      8'(OP_NOP1 + 8'd1), 8'h55, OP_NOP3, 8'h12, 8'h34, OP_OVERFLOW,
                      OP_OVERFLOW, 8'h20, OP_FLUX3, 8'hAB, 8'hCD, OP_OOB, BLK_FLUX2,
                      8'h05, OP_OOB, BLK_END, 8'h00, 8'h00, OP_OVERFLOW, 8'h03});
        // EOF block: the following byte is ignored
        send_stream('{OP_OOB, BLK_EOF, 8'hFF});
        drain();

        // Random phases, each under its own index limit
        for (int p = 0; p < NUM_PHASES; p++) begin
            limit = (p == NUM_PHASES - 1) ? 8'($urandom_range(0, 255)) : limit_steps[p];
            write_index_limit(limit);
            if (p == NUM_PHASES - 1) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            phase_start = beats_sent;
            if (p == 1) begin
                // long receiver hold while the sender keeps pushing flux bytes
                rx_hold_req = 1'b1;
                repeat (40) put_byte(8'($urandom_range(FLUX1_MIN, 255)));
            end
            if (p == 2) put_block(BLK_INFO, 256);
            while (beats_sent - phase_start < PHASE_BEATS) put_item(index_bias[p]);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (flux_check.mismatches == 0 && flux_check.expected_records.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
